// ----- src/glcd_pkg.sv -----
// shared constants, widths and helper functions for the graphic lcd controller
package glcd_pkg;

   localparam int HALF_COLUMNS = 64;
   localparam int PAGES        = 8;

   localparam int COL_W   = (HALF_COLUMNS > 1) ? $clog2(HALF_COLUMNS) : 1;
   localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int DEPTH   = PAGES * HALF_COLUMNS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] KIND_CMD   = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] OP_DISP_OFF  = 8'h3E;
   localparam logic [7:0] OP_DISP_ON   = 8'h3F;
   localparam logic [7:0] MASK_TOP2    = 8'hC0;
   localparam logic [7:0] MASK_TOP5    = 8'hF8;
   localparam logic [7:0] OP_SET_COL   = 8'h40;
   localparam logic [7:0] OP_SET_PAGE  = 8'hB8;
   localparam logic [7:0] OP_SET_START = 8'hC0;

   function automatic logic [COL_W-1:0] col_wrap(input logic [5:0] v);
      logic [6:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 8; i++) begin
         if (r >= 7'(HALF_COLUMNS)) begin
            r = r - 7'(HALF_COLUMNS);
         end
      end
      return r[COL_W-1:0];
   endfunction

   function automatic logic [PAGE_W-1:0] page_wrap(input logic [2:0] v);
      logic [3:0] r;
      r = {1'b0, v};
      for (int i = 0; i < 8; i++) begin
         if (r >= 4'(PAGES)) begin
            r = r - 4'(PAGES);
         end
      end
      return r[PAGE_W-1:0];
   endfunction

endpackage

// ----- src/dual_chip_glcd_controller_top.sv -----
// two-half graphic lcd controller with one display ram per half
//
//  channel  ports                                         direction
//  request  start busy req_cmd req_chip_select            in (busy out)
//           req_write_byte
//  response rsp_strobe rsp_read_byte rsp_display_enabled  out
//
// a word is taken whenever start is high, busy stays low
// the response appears in the cycle after the access, for one cycle only
// each half's ram read is registered; the output latch picks up that
// read word in the following cycle and is forwarded to a read right behind it
// reset clears addresses, display flags and latches; ram contents stay undefined
// the receiver cannot stall, so nothing waits on the response side
module dual_chip_glcd_controller_top
   import glcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_cmd,
   input  logic [1:0] req_chip_select,
   input  logic [7:0] req_write_byte,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_byte,
   output logic [1:0] rsp_display_enabled
);

   logic              accept;
   logic [PAGE_W-1:0] page_ff  [2];
   logic [PAGE_W-1:0] page_in  [2];
   logic [COL_W-1:0]  col_ff   [2];
   logic [COL_W-1:0]  col_in   [2];
   logic [5:0]        start_ff [2];
   logic [5:0]        start_in [2];
   logic [1:0]        on_ff;
   logic [1:0]        on_in;
   logic [7:0]        latch_ff [2];
   logic [7:0]        latch_in [2];
   logic [7:0]        rdata_ff [2];
   logic [1:0]        pend_ff;
   logic [1:0]        pend_in;
   logic [1:0]        wr_en;
   logic [ADDR_W-1:0] addr     [2];

   logic       strobe_ff;
   logic [7:0] rd_byte_ff;
   logic [7:0] rd_byte_in;
   logic [1:0] disp_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   for (genvar h = 0; h < 2; h++) begin : g_half
      logic [7:0]        mem [DEPTH];
      logic              sel;
      logic [COL_W-1:0]  col_next;

      assign sel      = accept && req_chip_select[h];
      assign col_next = (col_ff[h] == COL_W'(HALF_COLUMNS - 1)) ? '0 : col_ff[h] + COL_W'(1);
      assign addr[h]  = ADDR_W'(page_ff[h]) * ADDR_W'(HALF_COLUMNS) + ADDR_W'(col_ff[h]);

      always_comb begin
         page_in[h]  = page_ff[h];
         col_in[h]   = col_ff[h];
         start_in[h] = start_ff[h];
         on_in[h]    = on_ff[h];
         wr_en[h]    = 1'b0;
         pend_in[h]  = 1'b0;
         latch_in[h] = pend_ff[h] ? rdata_ff[h] : latch_ff[h];
         if (sel) begin
            unique case (req_cmd)
               KIND_CMD: begin
                  priority if (req_write_byte == OP_DISP_OFF) begin
                     on_in[h] = 1'b0;
                  end else if (req_write_byte == OP_DISP_ON) begin
                     on_in[h] = 1'b1;
                  end else if ((req_write_byte & MASK_TOP2) == OP_SET_COL) begin
                     col_in[h] = col_wrap(req_write_byte[5:0]);
                  end else if ((req_write_byte & MASK_TOP5) == OP_SET_PAGE) begin
                     page_in[h] = page_wrap(req_write_byte[2:0]);
                  end else if ((req_write_byte & MASK_TOP2) == OP_SET_START) begin
                     start_in[h] = req_write_byte[5:0];
                  end else begin
                  end
               end
               KIND_WRITE: begin
                  wr_en[h]  = 1'b1;
                  col_in[h] = col_next;
               end
               KIND_READ: begin
                  pend_in[h] = 1'b1;
                  col_in[h]  = col_next;
               end
               default: begin
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (wr_en[h]) begin
            mem[addr[h]] <= req_write_byte;
         end
         if (pend_in[h]) begin
            rdata_ff[h] <= mem[addr[h]];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            page_ff[h]  <= '0;
            col_ff[h]   <= '0;
            start_ff[h] <= '0;
            on_ff[h]    <= 1'b0;
            latch_ff[h] <= '0;
            pend_ff[h]  <= 1'b0;
         end else begin
            page_ff[h]  <= page_in[h];
            col_ff[h]   <= col_in[h];
            start_ff[h] <= start_in[h];
            on_ff[h]    <= on_in[h];
            latch_ff[h] <= latch_in[h];
            pend_ff[h]  <= pend_in[h];
         end
      end
   end

   always_comb begin
      rd_byte_in = '0;
      if (accept && req_cmd == KIND_READ) begin
         priority if (req_chip_select[0]) begin
            rd_byte_in = latch_in[0];
         end else if (req_chip_select[1]) begin
            rd_byte_in = latch_in[1];
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
      rd_byte_ff <= rd_byte_in;
      disp_ff    <= on_in;
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_read_byte       = rd_byte_ff;
   assign rsp_display_enabled = disp_ff;

`ifndef SYNTH
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("missing response word");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response word without access");

   a_no_sel_read: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == KIND_READ && req_chip_select == 2'b00) |=> rsp_read_byte == 8'h00)
      else $error("read with no half selected returned data");

   a_pend_from_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff[0] |-> $past(accept && req_cmd == KIND_READ && req_chip_select[0]))
      else $error("latch reload without read");

   a_disp_on: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == KIND_CMD && req_chip_select[1] && req_write_byte == OP_DISP_ON)
      |=> rsp_display_enabled[1])
      else $error("display on command not reflected");
`endif

endmodule

// ----- test/dual_chip_glcd_controller_top_tb.sv -----
// self-checking testbench for the two-half graphic lcd controller top level
`timescale 1ns / 1ps

module dual_chip_glcd_controller_top_tb;
   import glcd_pkg::*;

   localparam logic [1:0] KIND_NONE   = 2'd3;
   localparam int         STALL_LIMIT = 500;
   localparam int         TRAFFIC_WORDS = 900;
   localparam int         TOTAL_WORDS   = 1050;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [1:0] display_enabled;
   } access_rsp_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_cmd;
   logic [1:0] req_chip_select;
   logic [7:0] req_write_byte;
   logic       rsp_strobe;
   logic [7:0] rsp_read_byte;
   logic [1:0] rsp_display_enabled;

   logic [7:0]        ram_img     [2][DEPTH];
   bit                ram_written [2][DEPTH];
   logic [PAGE_W-1:0] page_reg    [2] = '{default: '0};
   logic [COL_W-1:0]  col_reg     [2] = '{default: '0};
   logic [5:0]        start_reg   [2] = '{default: '0};
   logic              disp_reg    [2] = '{default: 1'b0};
   logic [7:0]        latch_reg   [2] = '{default: '0};

   access_rsp_type pending_rsp[$];
   int          mismatch_count = 0;
   int          words_sent     = 0;
   int          stall_cycles   = 0;
   bit          idling_on      = 1'b1;

   dual_chip_glcd_controller_top DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_chip_select     (req_chip_select),
      .req_write_byte      (req_write_byte),
      .rsp_strobe          (rsp_strobe),
      .rsp_read_byte       (rsp_read_byte),
      .rsp_display_enabled (rsp_display_enabled)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int ram_slot(input int h);
      return int'(page_reg[h]) * HALF_COLUMNS + int'(col_reg[h]);
   endfunction

   function automatic bit read_is_safe(input logic [1:0] sel);
      bit ok;
      ok = 1'b1;
      for (int h = 0; h < 2; h++) begin
         if (sel[h] && !ram_written[h][ram_slot(h)]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic void step_column(input int h);
      col_reg[h] = COL_W'((int'(col_reg[h]) + 1) % HALF_COLUMNS);
   endfunction

   function automatic access_rsp_type lcd_access(input logic [1:0] kind,
                                                 input logic [1:0] sel,
                                                 input logic [7:0] b);
      access_rsp_type r;
      bit          have_rd;
      int          idx;
      r       = '0;
      have_rd = 1'b0;
      for (int h = 0; h < 2; h++) begin
         if (!sel[h]) begin
            continue;
         end
         idx = ram_slot(h);
         case (kind)
            KIND_CMD: begin
               if (b == OP_DISP_OFF) begin
                  disp_reg[h] = 1'b0;
               end else if (b == OP_DISP_ON) begin
                  disp_reg[h] = 1'b1;
               end else if ((b & MASK_TOP2) == OP_SET_COL) begin
                  col_reg[h] = COL_W'(int'(b[5:0]) % HALF_COLUMNS);
               end else if ((b & MASK_TOP5) == OP_SET_PAGE) begin
                  page_reg[h] = PAGE_W'(int'(b[2:0]) % PAGES);
               end else if ((b & MASK_TOP2) == OP_SET_START) begin
                  start_reg[h] = b[5:0];
               end
            end
            KIND_WRITE: begin
               ram_img[h][idx]     = b;
               ram_written[h][idx] = 1'b1;
               step_column(h);
            end
            KIND_READ: begin
               if (!have_rd) begin
                  r.read_byte = latch_reg[h];
                  have_rd     = 1'b1;
               end
               latch_reg[h] = ram_img[h][idx];
               step_column(h);
            end
            default: begin
            end
         endcase
      end
      r.display_enabled = {disp_reg[1], disp_reg[0]};
      return r;
   endfunction

   // a read whose latch reload would hit unwritten ram becomes a data write
   task automatic send_access(input logic [1:0] kind, input logic [1:0] sel,
                              input logic [7:0] b);
      logic [1:0] k;
      logic [7:0] d;
      k = kind;
      d = b;
      if (k == KIND_READ && !read_is_safe(sel)) begin
         k = KIND_WRITE;
         d = 8'($urandom);
      end
      start           <= 1'b1;
      req_cmd         <= k;
      req_chip_select <= sel;
      req_write_byte  <= d;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_rsp.push_back(lcd_access(k, sel, d));
      words_sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic send_noise();
      send_access(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom));
   endtask

   task automatic run_block_transfer();
      logic [1:0] sel;
      logic [2:0] pg;
      logic [5:0] c;
      int         len;
      sel = ($urandom_range(0, 15) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
      pg  = 3'($urandom);
      c   = 6'($urandom);
      len = $urandom_range(1, 12);
      send_access(KIND_CMD, sel, OP_SET_PAGE | 8'(pg));
      send_access(KIND_CMD, sel, OP_SET_COL | 8'(c));
      repeat (len) send_access(KIND_WRITE, sel, 8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
         send_access(KIND_CMD, sel, OP_SET_START | 8'($urandom_range(0, 63)));
      end
      if ($urandom_range(0, 3) == 0) begin
         send_access(KIND_CMD, 2'($urandom_range(0, 3)),
                     $urandom_range(0, 1) ? OP_DISP_ON : OP_DISP_OFF);
      end
      send_access(KIND_CMD, sel, OP_SET_COL | 8'(c));
      repeat (len + 1) send_access(KIND_READ, sel, 8'($urandom));
   endtask

   task automatic test_reset_state();
      send_access(KIND_NONE, 2'd3, 8'hFF);
      send_access(KIND_READ, 2'd0, 8'h00);
      send_access(KIND_CMD, 2'd0, OP_DISP_ON);
   endtask

   task automatic test_display_commands();
      send_access(KIND_CMD, 2'd1, OP_DISP_ON);
      send_access(KIND_CMD, 2'd2, OP_DISP_ON);
      send_access(KIND_CMD, 2'd1, OP_DISP_OFF);
      send_access(KIND_CMD, 2'd3, OP_DISP_ON);
      send_access(KIND_CMD, 2'd3, 8'h00);
      send_access(KIND_CMD, 2'd3, 8'hB7);
      send_access(KIND_CMD, 2'd3, 8'h3D);
      send_access(KIND_CMD, 2'd2, OP_DISP_OFF);
   endtask

   task automatic test_column_wrap();
      send_access(KIND_CMD, 2'd3, OP_SET_PAGE | 8'h07);
      send_access(KIND_CMD, 2'd3, OP_SET_COL | 8'h3F);
      send_access(KIND_CMD, 2'd3, OP_SET_START | 8'h3F);
      send_access(KIND_WRITE, 2'd3, 8'hFF);
      send_access(KIND_WRITE, 2'd3, 8'h00);
      send_access(KIND_WRITE, 2'd3, 8'hA5);
      send_access(KIND_CMD, 2'd3, OP_SET_COL | 8'h3F);
      send_access(KIND_READ, 2'd3, 8'h00);
      send_access(KIND_READ, 2'd3, 8'h00);
      send_access(KIND_READ, 2'd3, 8'h00);
   endtask

   task automatic test_random_traffic();
      while (words_sent < TRAFFIC_WORDS) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 6)) send_noise();
         end else begin
            run_block_transfer();
         end
      end
   endtask

   task automatic test_back_to_back();
      idling_on = 1'b0;
      while (words_sent < TOTAL_WORDS) begin
         if ($urandom_range(0, 5) == 0) begin
            send_noise();
         end else begin
            run_block_transfer();
         end
      end
   endtask

   always @(posedge clock) begin : check_response
      access_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing expected");
            mismatch_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_read_byte !== want.read_byte) begin
               $error("read_byte expected %0h actual %0h", want.read_byte, rsp_read_byte);
               mismatch_count++;
            end
            if (rsp_display_enabled !== want.display_enabled) begin
               $error("display_enabled expected %0h actual %0h",
                      want.display_enabled, rsp_display_enabled);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("dual_chip_glcd_controller_top verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_cmd         <= KIND_CMD;
      req_chip_select <= 2'd0;
      req_write_byte  <= 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_display_commands();
      test_column_wrap();
      test_random_traffic();
      test_back_to_back();
      start <= 1'b0;
      while (pending_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("dual_chip_glcd_controller_top verification clean");
      end else begin
         $display("dual_chip_glcd_controller_top verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/glcd_pkg.sv
src/dual_chip_glcd_controller_top.sv
test/dual_chip_glcd_controller_top_tb.sv
